// ===== hw/rtl/tlca_pkg.sv =====
// Shared constants and types for the tree lowest-common-ancestor block.
// No dependencies; compiled first.
package tlca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = 10;
   localparam int DEPTH_W     = $clog2(MAX_NODES + 1);
   localparam int TABLE_DEPTH = 1 << NODE_W;

   localparam logic FUNC_LINK  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [NODE_W-1:0] VIRTUAL_TOP = '0;
   localparam logic [NODE_W-1:0] ROOT_NODE   = NODE_W'(1);

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_ACCEPT,
      DP_DEPTH_ADV,
      DP_RESTORE,
      DP_LIFT_ADV,
      DP_PAIR_ADV,
      DP_FAIL,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      logic query_taken;
      logic clear_last;
      logic depth_done;
      logic depth_fail;
      logic depth_equal;
      logic met;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== hw/rtl/tlca_req_if.sv =====
// Request channel: valid/ready handshake with link/query payload.
// Depends on tlca_pkg.
interface tlca_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [tlca_pkg::NODE_W-1:0] node_a;
   logic [tlca_pkg::NODE_W-1:0] node_b;

   modport source (output valid, func, node_a, node_b, input ready);
   modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

// ===== hw/rtl/tlca_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the common ancestor.
// Depends on tlca_pkg.
interface tlca_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tlca_pkg::NODE_W-1:0] ancestor;

   modport source (output valid, ancestor, input ready);
   modport sink   (input valid, ancestor, output ready);
endinterface

// ===== hw/rtl/tlca_sequencer.sv =====
// Microcode sequencer: step counter, control-word ROM and branch logic.
// Depends on tlca_pkg.
module tlca_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  tlca_pkg::dp_status_type status,
   output tlca_pkg::dp_ctrl_type   ctrl
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DCHK,
      ST_DADV,
      ST_RESTORE,
      ST_LCHK,
      ST_LADV,
      ST_TCHK,
      ST_TADV,
      ST_FAIL,
      ST_EMIT
   } step_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_CLEAR_LAST,
      C_QUERY_TAKEN,
      C_DEPTH_DONE,
      C_DEPTH_FAIL,
      C_DEPTH_EQUAL,
      C_MET,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      tlca_pkg::dp_op_type op;
      cond_type            cond;
      step_type            jmp;
      step_type            nxt;
   } uword_type;

   // next = cond ? jmp : nxt
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      begin
         case (s)
            ST_CLEAR:   w = '{tlca_pkg::DP_CLEAR,     C_CLEAR_LAST,  ST_IDLE,  ST_CLEAR};
            ST_IDLE:    w = '{tlca_pkg::DP_ACCEPT,    C_QUERY_TAKEN, ST_DCHK,  ST_IDLE};
            ST_DCHK:    w = '{tlca_pkg::DP_NOP,       C_DEPTH_DONE,  ST_RESTORE, ST_DADV};
            ST_DADV:    w = '{tlca_pkg::DP_DEPTH_ADV, C_DEPTH_FAIL,  ST_FAIL,  ST_DCHK};
            ST_RESTORE: w = '{tlca_pkg::DP_RESTORE,   C_NEVER,       ST_IDLE,  ST_LCHK};
            ST_LCHK:    w = '{tlca_pkg::DP_NOP,       C_DEPTH_EQUAL, ST_TCHK,  ST_LADV};
            ST_LADV:    w = '{tlca_pkg::DP_LIFT_ADV,  C_NEVER,       ST_IDLE,  ST_LCHK};
            ST_TCHK:    w = '{tlca_pkg::DP_NOP,       C_MET,         ST_EMIT,  ST_TADV};
            ST_TADV:    w = '{tlca_pkg::DP_PAIR_ADV,  C_NEVER,       ST_IDLE,  ST_TCHK};
            ST_FAIL:    w = '{tlca_pkg::DP_FAIL,      C_NEVER,       ST_IDLE,  ST_EMIT};
            ST_EMIT:    w = '{tlca_pkg::DP_EMIT,      C_OUT_BUSY,    ST_EMIT,  ST_IDLE};
            default:    w = '{tlca_pkg::DP_NOP,       C_NEVER,       ST_IDLE,  ST_IDLE};
         endcase
         return w;
      end
   endfunction

   step_type  pc_ff;
   step_type  pc_in;
   uword_type word;
   logic      take;

   always_comb begin
      word = ucode(pc_ff);
      case (word.cond)
         C_NEVER:       take = 1'b0;
         C_CLEAR_LAST:  take = status.clear_last;
         C_QUERY_TAKEN: take = status.query_taken;
         C_DEPTH_DONE:  take = status.depth_done;
         C_DEPTH_FAIL:  take = status.depth_fail;
         C_DEPTH_EQUAL: take = status.depth_equal;
         C_MET:         take = status.met;
         C_OUT_BUSY:    take = status.out_busy;
         default:       take = 1'b0;
      endcase
      pc_in   = take ? word.jmp : word.nxt;
      ctrl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/tlca_datapath.sv =====
// Datapath: parent table memory, two walk pointers with depth counters,
// and the response register. Driven by the control word of tlca_sequencer.
// Depends on tlca_pkg, tlca_req_if, tlca_rsp_if.
module tlca_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  tlca_pkg::dp_ctrl_type   ctrl,
   output tlca_pkg::dp_status_type status,
   tlca_req_if.sink                req,
   tlca_rsp_if.source              rsp
);

   localparam int NW = tlca_pkg::NODE_W;
   localparam int DW = tlca_pkg::DEPTH_W;
   localparam logic [DW-1:0] DEPTH_CAP = DW'(tlca_pkg::MAX_NODES);

   logic [NW-1:0] mem [tlca_pkg::TABLE_DEPTH];

   logic [NW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [NW-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [DW-1:0] da_ff, da_in, db_ff, db_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] rda_ff, rdb_ff;
   logic [NW-1:0] anc_ff, anc_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          accept;
   logic          busy;
   logic          load;
   logic          we;
   logic [NW-1:0] waddr;
   logic [NW-1:0] wdata;

   assign req.ready    = (ctrl.op == tlca_pkg::DP_ACCEPT);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.ancestor = anc_ff;

   always_comb begin
      accept = req.valid && req.ready;
      busy   = rsp_valid_ff && !rsp.ready;
      load   = (ctrl.op == tlca_pkg::DP_EMIT) && !busy;

      pa_in  = pa_ff;
      pb_in  = pb_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      da_in  = da_ff;
      db_in  = db_ff;
      clr_in = clr_ff;
      anc_in = anc_ff;
      we     = 1'b0;
      waddr  = clr_ff;
      wdata  = '0;

      case (ctrl.op)
         tlca_pkg::DP_CLEAR: begin
            we     = 1'b1;
            clr_in = clr_ff + NW'(1);
         end
         tlca_pkg::DP_ACCEPT: begin
            if (accept && req.func == tlca_pkg::FUNC_QUERY) begin
               pa_in = req.node_a;
               na_in = req.node_a;
               pb_in = req.node_b;
               nb_in = req.node_b;
               da_in = '0;
               db_in = '0;
            end else if (accept) begin
               // virtual top and root keep their parents
               waddr = req.node_a;
               wdata = req.node_b;
               we    = (req.node_a != tlca_pkg::VIRTUAL_TOP) &&
                       (req.node_a != tlca_pkg::ROOT_NODE);
            end
         end
         tlca_pkg::DP_DEPTH_ADV: begin
            if (pa_ff != tlca_pkg::VIRTUAL_TOP) begin
               pa_in = rda_ff;
               da_in = da_ff + DW'(1);
            end
            if (pb_ff != tlca_pkg::VIRTUAL_TOP) begin
               pb_in = rdb_ff;
               db_in = db_ff + DW'(1);
            end
         end
         tlca_pkg::DP_RESTORE: begin
            pa_in = na_ff;
            pb_in = nb_ff;
         end
         tlca_pkg::DP_LIFT_ADV: begin
            if (da_ff > db_ff) begin
               pa_in = rda_ff;
               da_in = da_ff - DW'(1);
            end else begin
               pb_in = rdb_ff;
               db_in = db_ff - DW'(1);
            end
         end
         tlca_pkg::DP_PAIR_ADV: begin
            pa_in = rda_ff;
            pb_in = rdb_ff;
            da_in = da_ff - DW'(1);
         end
         tlca_pkg::DP_FAIL: begin
            pa_in = tlca_pkg::VIRTUAL_TOP;
            pb_in = tlca_pkg::VIRTUAL_TOP;
         end
         tlca_pkg::DP_EMIT: begin
            if (load) begin
               anc_in = (pa_ff == pb_ff) ? pa_ff : tlca_pkg::VIRTUAL_TOP;
            end
         end
         default: begin
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      status.query_taken = accept && (req.func == tlca_pkg::FUNC_QUERY);
      status.clear_last  = (clr_ff == '1);
      status.depth_done  = (pa_ff == tlca_pkg::VIRTUAL_TOP) &&
                           (pb_ff == tlca_pkg::VIRTUAL_TOP);
      status.depth_fail  = ((pa_ff != tlca_pkg::VIRTUAL_TOP) && (da_ff >= DEPTH_CAP)) ||
                           ((pb_ff != tlca_pkg::VIRTUAL_TOP) && (db_ff >= DEPTH_CAP));
      status.depth_equal = (da_ff == db_ff);
      status.met         = (pa_ff == pb_ff) || (da_ff == '0);
      status.out_busy    = busy;
   end

   // parent table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rda_ff <= mem[pa_ff];
      rdb_ff <= mem[pb_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      na_ff  <= na_in;
      nb_ff  <= nb_in;
      da_ff  <= da_in;
      db_ff  <= db_in;
      anc_ff <= anc_in;
   end

endmodule

// ===== hw/rtl/tree_lowest_common_ancestor.sv =====
// Top level of the tree lowest-common-ancestor block: sequencer plus datapath.
// Depends on tlca_pkg, tlca_req_if, tlca_rsp_if, tlca_sequencer, tlca_datapath.
//
//   channel | dir | payload                  | notes
//   --------+-----+--------------------------+------------------------------
//   req     | in  | func, node_a, node_b     | link (func=0) or query (func=1)
//   rsp     | out | ancestor                 | one per query, none per link
//
// A link writes its parent entry when it is taken. A query counts both depths
// in parallel, then lifts the deeper node, then steps both nodes jointly.
// Each walk step costs one registered table read. After reset a clearing pass
// writes all 1024 table entries, during which req.ready stays low. A stalled
// response waits in the output register; links are still taken meanwhile,
// and a query stalls only at emit.
module tree_lowest_common_ancestor (
   input  logic       clock,
   input  logic       reset,
   tlca_req_if.sink   req,
   tlca_rsp_if.source rsp
);

   tlca_pkg::dp_ctrl_type   ctrl;
   tlca_pkg::dp_status_type status;

   tlca_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tlca_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );

endmodule

// ===== hw/rtl/tlca_checker.sv =====
// Port-level checks for tree_lowest_common_ancestor, attached with bind.
// Depends on tlca_pkg and the top level.
module tlca_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tlca_pkg::NODE_W-1:0] rsp_ancestor
);

   // clearing pass starts right out of reset
   a_ready_low_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during table clear");

   // no request answers in the cycle right after it is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("response appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_ancestor))
      else $error("response changed while stalled");

endmodule

bind tree_lowest_common_ancestor tlca_checker u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_ancestor (rsp.ancestor)
);
